// ===== design/assert_macros.svh =====
// assertion helpers, clocked on clk with reset held off
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be true
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

// ===== design/smdm_pkg.sv =====
`default_nettype none
package smdm_pkg;

	localparam int unsigned OpW   = 2;
	localparam int unsigned OperW = 16;
	localparam int unsigned ProdW = 32;
	localparam int unsigned SumW  = 40;
	localparam int unsigned NumSteps = OperW;
	localparam int unsigned CntW  = $clog2(NumSteps);

	localparam logic ModeWrite = 1'b0;
	localparam logic ModeRead  = 1'b1;

	localparam logic [OpW-1:0] OpMul = 2'd0;
	localparam logic [OpW-1:0] OpDiv = 2'd1;

	localparam logic [8:0] OffCtrl = 9'h050;
	localparam logic [8:0] OffALo  = 9'h051;
	localparam logic [8:0] OffAHi  = 9'h052;
	localparam logic [8:0] OffBLo  = 9'h053;
	localparam logic [8:0] OffBHi  = 9'h054;
	localparam logic [8:0] OffRes0 = 9'h106;
	localparam logic [8:0] OffRes1 = 9'h107;
	localparam logic [8:0] OffRes2 = 9'h108;
	localparam logic [8:0] OffRes3 = 9'h109;
	localparam logic [8:0] OffRes4 = 9'h10A;
	localparam logic [8:0] OffOvf  = 9'h10B;

	localparam logic [7:0] OvfByte = 8'h80;

	typedef enum logic {
		T_IDLE,
		T_BUSY
	} top_state_t;

	typedef enum logic [1:0] {
		A_IDLE,
		A_ITER,
		A_FIX
	} alu_state_t;

	typedef struct packed {
		logic             start;
		logic             is_div;
		logic [OperW-1:0] a;
		logic [OperW-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic             done;
		logic [ProdW-1:0] result;
	} alu_sts_t;

endpackage
`default_nettype wire

// ===== design/signed_mul_div_mac_unit.sv =====
`default_nettype none
// Byte-wide register front end to a signed multiply, divide and multiply-accumulate
// unit. Every accepted item gives one read_data item on the next cycle from an output
// register (zero for writes). A write to the high byte of operand B starts the
// selected operation on a shared 17-bit add/subtract unit: the operands load at the
// accepting edge, then come 16 shift-add or restoring-divide steps, a sign-correction
// step and the write-back of the result, and in_ready stays low until that write-back.
// After that, and for every other item, the next item goes in once the read_data item
// of the last one has been taken.
module signed_mul_div_mac_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       mode,
	input  wire logic [8:0] reg_offset,
	input  wire logic [7:0] write_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      read_data
);
	import smdm_pkg::*;

	`include "assert_macros.svh"

	top_state_t state_q, state_d;

	logic [OpW-1:0]   op_q;
	logic [OperW-1:0] a_q;
	logic [7:0]       b_q;
	logic [SumW-1:0]  sum_q;
	logic             ovf_q;
	logic             out_valid_q;
	logic [7:0]       out_data_q;

	logic     in_acc;
	logic     wr_acc;
	logic     start_op;
	alu_req_t alu_req;
	alu_sts_t alu_sts;
	logic [SumW:0] acc_raw;
	logic [7:0]    rd_byte;

	assign in_acc   = in_valid && in_ready;
	assign wr_acc   = in_acc && (mode == ModeWrite);
	assign start_op = wr_acc && (reg_offset == OffBHi);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE: if (start_op) state_d = T_BUSY;
			T_BUSY: if (alu_sts.done) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		unique case (state_q)
			T_IDLE: in_ready = !out_valid_q || out_ready;
			T_BUSY: in_ready = 1'b0;
			default: ;
		endcase
	end

	assign alu_req.start  = start_op;
	assign alu_req.is_div = (op_q == OpDiv);
	assign alu_req.a      = a_q;
	assign alu_req.b      = {write_data, b_q};

	smdm_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.sts    (alu_sts)
	);

	assign acc_raw = {1'b0, sum_q}
		+ {{(SumW + 1 - ProdW){alu_sts.result[ProdW-1]}}, alu_sts.result};

	always_comb begin
		rd_byte = '0;
		if (mode == ModeRead) begin
			unique case (reg_offset)
				OffRes0: rd_byte = sum_q[7:0];
				OffRes1: rd_byte = sum_q[15:8];
				OffRes2: rd_byte = sum_q[23:16];
				OffRes3: rd_byte = sum_q[31:24];
				OffRes4: rd_byte = sum_q[39:32];
				OffOvf:  rd_byte = ovf_q ? OvfByte : 8'h00;
				default: rd_byte = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			op_q        <= OpMul;
			a_q         <= '0;
			b_q         <= '0;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_acc) begin
				unique case (reg_offset)
					OffCtrl: begin
						op_q <= write_data[OpW-1:0];
						if (write_data[1]) sum_q <= '0;
					end
					OffALo: a_q[7:0]  <= write_data;
					OffAHi: a_q[15:8] <= write_data;
					OffBLo: b_q       <= write_data;
					OffBHi: begin
						// operand B is consumed by the operation, and operand A too for a divide
						b_q <= '0;
						if (op_q == OpDiv) a_q <= '0;
					end
					default: ;
				endcase
			end else if (alu_sts.done) begin
				if (op_q[1]) begin
					sum_q <= acc_raw[SumW-1:0];
					ovf_q <= acc_raw[SumW];
				end else begin
					sum_q <= {{(SumW - ProdW){1'b0}}, alu_sts.result};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_data_q <= rd_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = out_data_q;

	`ASSERT_NEVER(a_no_accept_busy, (state_q == T_BUSY) && in_ready, "item accepted while busy")
	`ASSERT_CLK(a_done_when_busy, alu_sts.done |-> (state_q == T_BUSY), "alu done while idle")
	`ASSERT_CLK(a_start_busy, start_op |=> (state_q == T_BUSY), "operation start did not go busy")

endmodule
`default_nettype wire

// ===== design/smdm_alu.sv =====
`default_nettype none
module smdm_alu (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire smdm_pkg::alu_req_t req,
	output smdm_pkg::alu_sts_t     sts
);
	import smdm_pkg::*;

	alu_state_t state_q, state_d;
	logic iter_en, fix_en, load_en;

	logic [CntW-1:0]  cnt_q;
	logic [OperW-1:0] hi_q;
	logic [OperW-1:0] lo_q;
	logic [OperW-1:0] y_q;
	logic             neg_q;
	logic             div_q;
	logic [ProdW-1:0] res_q;
	logic             done_q;

	// shared add / subtract unit
	logic [OperW:0]   au_x;
	logic [OperW:0]   au_y;
	logic             au_sub;
	logic [OperW+1:0] au_y_ext;
	logic [OperW+1:0] au_res;

	logic [OperW-1:0] a_mag, b_mag;
	logic [ProdW-1:0] prod_mag;
	logic [OperW-1:0] r0, q_neg, r_neg;
	logic             r0_nz;
	logic [ProdW-1:0] fix_res;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			A_IDLE: if (req.start) state_d = A_ITER;
			A_ITER: if (cnt_q == CntW'(NumSteps - 1)) state_d = A_FIX;
			A_FIX:  state_d = A_IDLE;
			default: state_d = A_IDLE;
		endcase
	end

	always_comb begin
		load_en = 1'b0;
		iter_en = 1'b0;
		fix_en  = 1'b0;
		unique case (state_q)
			A_IDLE: load_en = req.start;
			A_ITER: iter_en = 1'b1;
			A_FIX:  fix_en  = 1'b1;
			default: ;
		endcase
	end

	assign a_mag = req.a[OperW-1] ? (~req.a + 1'b1) : req.a;
	assign b_mag = req.b[OperW-1] ? (~req.b + 1'b1) : req.b;

	always_comb begin
		if (div_q) begin
			// shift remainder left, bring in next dividend bit, trial subtract
			au_x   = {hi_q, lo_q[OperW-1]};
			au_y   = {1'b0, y_q};
			au_sub = 1'b1;
		end else begin
			au_x   = {1'b0, hi_q};
			au_y   = lo_q[0] ? {1'b0, y_q} : '0;
			au_sub = 1'b0;
		end
		au_y_ext = au_sub ? ~{1'b0, au_y} : {1'b0, au_y};
		au_res   = {1'b0, au_x} + au_y_ext + {{(OperW+1){1'b0}}, au_sub};
	end

	// sign correction after the last step
	assign prod_mag = {hi_q, lo_q};
	assign r0       = hi_q;
	assign r0_nz    = (r0 != '0);
	assign q_neg    = ~(lo_q + {{(OperW-1){1'b0}}, r0_nz}) + 1'b1;
	assign r_neg    = r0_nz ? (y_q - r0) : '0;

	always_comb begin
		if (!div_q) begin
			fix_res = neg_q ? (~prod_mag + 1'b1) : prod_mag;
		end else if (y_q == '0) begin
			fix_res = '0;
		end else if (neg_q) begin
			fix_res = {r_neg, q_neg};
		end else begin
			fix_res = {r0, lo_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fix_en;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			cnt_q <= '0;
			hi_q  <= '0;
			div_q <= req.is_div;
			if (req.is_div) begin
				lo_q  <= a_mag;
				y_q   <= req.b;
				neg_q <= req.a[OperW-1];
			end else begin
				lo_q  <= b_mag;
				y_q   <= a_mag;
				neg_q <= req.a[OperW-1] ^ req.b[OperW-1];
			end
		end else if (iter_en) begin
			cnt_q <= cnt_q + 1'b1;
			if (div_q) begin
				// no borrow means the divisor fits
				if (!au_res[OperW+1]) begin
					hi_q <= au_res[OperW-1:0];
					lo_q <= {lo_q[OperW-2:0], 1'b1};
				end else begin
					hi_q <= au_x[OperW-1:0];
					lo_q <= {lo_q[OperW-2:0], 1'b0};
				end
			end else begin
				hi_q <= au_res[OperW:1];
				lo_q <= {au_res[0], lo_q[OperW-1:1]};
			end
		end
		if (fix_en) begin
			res_q <= fix_res;
		end
	end

	assign sts.done   = done_q;
	assign sts.result = res_q;

endmodule
`default_nettype wire
